// ===== hw/rtl/slot_allocator_linked_free_list_macros.svh =====
// Assertion macros shared by the slot allocator RTL.
`ifndef SLOT_ALLOCATOR_LINKED_FREE_LIST_MACROS_SVH
`define SLOT_ALLOCATOR_LINKED_FREE_LIST_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SLFL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slfl_pkg.sv =====
// Types and constants for the slot allocator.
package slfl_pkg;

  // Pool geometry; the value SLOTS is the "no slot" link.
  localparam int unsigned SLOTS  = 256;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned LINK_W = 9;
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  // Request item
  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  // Result item
  typedef struct packed {
    status_t           status;
    logic [LINK_W-1:0] granted_slot;
    logic [LINK_W-1:0] used_count;
    logic              pool_full;
    logic              pool_empty;
    logic [LINK_W-1:0] newest_slot;
  } rsp_t;

  // Write port of a link memory
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

endpackage

// ===== hw/rtl/slfl_link_ram.sv =====
// Link memory without reset: one write port, one registered read port with bypass.
module slfl_link_ram (
  input  logic                            clk,
  input  slfl_pkg::link_wr_t              wr,
  input  logic [slfl_pkg::IDX_W-1:0]      raddr,
  output logic [slfl_pkg::LINK_W-1:0]     rdata
);

  logic [slfl_pkg::LINK_W-1:0] mem [slfl_pkg::SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, a same-edge write to the read address wins
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == raddr)) begin
      rdata <= wr.data;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/slfl_free_ram.sv =====
// Free-list link memory: per-entry valid bits make unwritten entries read as index plus one.
module slfl_free_ram (
  input  logic                            clk,
  input  logic                            rst,
  input  slfl_pkg::link_wr_t              wr,
  input  logic [slfl_pkg::IDX_W-1:0]      raddr,
  output logic [slfl_pkg::LINK_W-1:0]     rdata
);

  logic [slfl_pkg::LINK_W-1:0] mem [slfl_pkg::SLOTS];
  logic [slfl_pkg::SLOTS-1:0]  valid;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // valid bits and registered read; after reset the head is slot 0, whose link is 1
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rdata <= slfl_pkg::LINK_W'(1);
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (wr.en && (wr.addr == raddr)) begin
        rdata <= wr.data;
      end else if (valid[raddr]) begin
        rdata <= mem[raddr];
      end else begin
        rdata <= slfl_pkg::LINK_W'(raddr) + slfl_pkg::LINK_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/slot_allocator_linked_free_list.sv =====
// Top level of the slot allocator: request stage, list update and result register.
// A new request may be issued on every cycle (busy is high only during reset).
// Each request's result appears on rsp, marked by done, for exactly one cycle;
// a request passes through the request stage register and then the result
// register. Results come out in request order and the receiver cannot
// stall them. Link storage is three 256-entry memories
// with one write and one registered read each: the free-list successor link
// (read ahead at the free head every cycle), and the allocated-list successor
// and predecessor links (read at the request's slot_index when it is taken).
// Same-edge writes are bypassed into the reads. No clearing pass is needed
// after reset; the free links use per-entry valid bits.
`include "slot_allocator_linked_free_list_macros.svh"

module slot_allocator_linked_free_list (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  slfl_pkg::req_t   req,
  output logic             done,
  output slfl_pkg::rsp_t   rsp
);

  localparam int unsigned IW = slfl_pkg::IDX_W;
  localparam int unsigned LW = slfl_pkg::LINK_W;

  // list state
  logic [LW-1:0]              free_head, free_head_next;
  logic [LW-1:0]              used_head, used_head_next;
  logic [LW-1:0]              used_total, used_total_next;
  logic [slfl_pkg::SLOTS-1:0] in_use, in_use_next;

  // request stage
  logic          s1_valid;
  logic          s1_mode;
  logic [IW-1:0] s1_idx;

  // memory ports
  slfl_pkg::link_wr_t fnext_wr, unext_wr, uprev_wr;
  logic [LW-1:0]      fnext_rd, unext_rd, uprev_rd;

  slfl_pkg::rsp_t rsp_next;
  logic           accept;
  logic           alloc_ok, rel_ok, rel_head;

  assign busy   = rst;
  assign accept = start && !busy;

  // request stage capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= req.mode;
      s1_idx  <= req.slot_index;
    end
  end

  // link memories
  slfl_free_ram u_fnext (
    .clk   (clk),
    .rst   (rst),
    .wr    (fnext_wr),
    .raddr (free_head_next[IW-1:0]),
    .rdata (fnext_rd)
  );

  slfl_link_ram u_unext (
    .clk   (clk),
    .wr    (unext_wr),
    .raddr (req.slot_index),
    .rdata (unext_rd)
  );

  slfl_link_ram u_uprev (
    .clk   (clk),
    .wr    (uprev_wr),
    .raddr (req.slot_index),
    .rdata (uprev_rd)
  );

  // list update for the item in the request stage
  always_comb begin
    free_head_next  = free_head;
    used_head_next  = used_head;
    used_total_next = used_total;
    in_use_next     = in_use;
    fnext_wr        = '0;
    unext_wr        = '0;
    uprev_wr        = '0;
    alloc_ok        = 1'b0;
    rel_ok          = 1'b0;
    rel_head        = (used_head == LW'(s1_idx));
    rsp_next        = '0;
    rsp_next.status = slfl_pkg::ST_OK;

    if (s1_valid) begin
      if (s1_mode == slfl_pkg::MODE_ALLOC) begin
        if (free_head == slfl_pkg::LINK_NONE) begin
          rsp_next.status = slfl_pkg::ST_FULL;
        end else begin
          alloc_ok = 1'b1;
        end
      end else begin
        if (LW'(s1_idx) >= slfl_pkg::LINK_NONE) begin
          rsp_next.status = slfl_pkg::ST_RANGE;
        end else if (!in_use[s1_idx] || (used_head == slfl_pkg::LINK_NONE)) begin
          rsp_next.status = slfl_pkg::ST_NOT_USED;
        end else begin
          rel_ok = 1'b1;
        end
      end
    end

    // allocate: pop free head, push it on the allocated list
    if (alloc_ok) begin
      free_head_next                   = fnext_rd;
      used_head_next                   = free_head;
      in_use_next[free_head[IW-1:0]]   = 1'b1;
      used_total_next                  = used_total + LW'(1);
      unext_wr.en                      = 1'b1;
      unext_wr.addr                    = free_head[IW-1:0];
      unext_wr.data                    = used_head;
      uprev_wr.en                      = (used_head != slfl_pkg::LINK_NONE);
      uprev_wr.addr                    = used_head[IW-1:0];
      uprev_wr.data                    = free_head;
    end

    // release: unlink from the allocated list, push on the free list
    // (the head's predecessor link is never kept, so the successor gets none)
    if (rel_ok) begin
      if (rel_head) begin
        used_head_next = unext_rd;
      end else begin
        unext_wr.en   = 1'b1;
        unext_wr.addr = uprev_rd[IW-1:0];
        unext_wr.data = unext_rd;
      end
      uprev_wr.en         = (unext_rd != slfl_pkg::LINK_NONE);
      uprev_wr.addr       = unext_rd[IW-1:0];
      uprev_wr.data       = rel_head ? slfl_pkg::LINK_NONE : uprev_rd;
      fnext_wr.en         = 1'b1;
      fnext_wr.addr       = s1_idx;
      fnext_wr.data       = free_head;
      free_head_next      = LW'(s1_idx);
      in_use_next[s1_idx] = 1'b0;
      if (used_total != '0) begin
        used_total_next = used_total - LW'(1);
      end
    end

    rsp_next.granted_slot = alloc_ok ? free_head : slfl_pkg::LINK_NONE;
    rsp_next.used_count   = used_total_next;
    rsp_next.pool_full    = (free_head_next == slfl_pkg::LINK_NONE);
    rsp_next.pool_empty   = (used_head_next == slfl_pkg::LINK_NONE);
    rsp_next.newest_slot  = used_head_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      used_head  <= slfl_pkg::LINK_NONE;
      used_total <= '0;
      in_use     <= '0;
    end else begin
      free_head  <= free_head_next;
      used_head  <= used_head_next;
      used_total <= used_total_next;
      in_use     <= in_use_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      rsp <= rsp_next;
    end
  end

  // checks
  `SLFL_ASSERT_NEXT(a_stage_to_result, clk, rst, s1_valid, done, "taken item gave no result")
  `SLFL_ASSERT_NOW(a_empty_count, clk, rst, done,
    rsp.pool_empty == (rsp.used_count == '0), "empty flag disagrees with count")
  `SLFL_ASSERT_NOW(a_full_count, clk, rst, done,
    rsp.pool_full == (rsp.used_count == slfl_pkg::LINK_NONE), "full flag disagrees with count")
  `SLFL_ASSERT_NOW(a_grant_newest, clk, rst, done && (rsp.granted_slot != slfl_pkg::LINK_NONE),
    rsp.newest_slot == rsp.granted_slot, "granted slot is not the newest")

endmodule
